// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Each helper expects a clock named i_clk and an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cnms_pkg.sv =====
// ----------------------------------------------------------------------------
// cnms_pkg
// Shared types and constants for the Canny non-maximum suppression block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cnms_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int MAG_W   = 8;
    localparam int ANGLE_W = 10;
    localparam int POS_W   = 10;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] FRAME_DIM_RESET = CFG_W'(512);

    // Angle band edges in half-degrees, folded onto 0..359
    localparam logic [ANGLE_W-1:0] ANG_FULL  = ANGLE_W'(720);
    localparam logic [ANGLE_W-1:0] ANG_HALF  = ANGLE_W'(360);
    localparam logic [ANGLE_W-1:0] ANG_B22   = ANGLE_W'(45);
    localparam logic [ANGLE_W-1:0] ANG_B67   = ANGLE_W'(135);
    localparam logic [ANGLE_W-1:0] ANG_B112  = ANGLE_W'(225);
    localparam logic [ANGLE_W-1:0] ANG_B157  = ANGLE_W'(315);

    typedef struct packed {
        logic [MAG_W-1:0]   grad_magnitude;
        logic [ANGLE_W-1:0] grad_angle;
    } t_pixel_in;

    typedef struct packed {
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic [MAG_W-1:0] thinned_value;
    } t_pixel_out;

endpackage

`default_nettype wire

// ===== rtl/core/canny_non_maxima_suppression.sv =====
// ----------------------------------------------------------------------------
// canny_non_maxima_suppression
// 3x3 non-maximum suppression over a raster stream of gradient pixels.
// ----------------------------------------------------------------------------
//   Input  : i_in_valid / o_in_stall / i_in_item. One pixel per item in raster
//            order: 8-bit magnitude and gradient angle in half-degrees.
//   Output : o_out_valid / i_out_stall / o_out_item. One item per interior
//            pixel (row, column, thinned magnitude); borders produce nothing.
//   Config : i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data. Index 0 is
//            frame width, index 1 frame height. Any write, to any index,
//            restarts the frame at row 0, column 0. Write only while idle.
//   Timing : one item per clock unless the output stalls. Accepted items sit
//            in stage 1 for the line-buffer read, then in the output register.
//   Reset  : synchronous, active low. Frame size returns to 512x512; counters
//            and the window clear. Line buffers are not cleared; the frame
//            restart keeps stale lines out of every result.
//   Stall  : while the output register is full and stalled, stage 1 holds and
//            o_in_stall rises once stage 1 is occupied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module canny_non_maxima_suppression #(
    parameter int MAX_WIDTH  = cnms_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cnms_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // pixel input
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire cnms_pkg::t_pixel_in            i_in_item,
    // result output
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output cnms_pkg::t_pixel_out                o_out_item,
    // register writes
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [cnms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [cnms_pkg::CFG_W-1:0]     i_cfg_data
);

    import cnms_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WD_W   = $clog2(MAX_WIDTH + 1);
    localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
    localparam int DIM_A  = (WD_W > HD_W) ? WD_W : HD_W;
    localparam int DIM_W  = (DIM_A > CFG_W) ? DIM_A : CFG_W;
    localparam int RX_W   = (ROW_W > POS_W) ? ROW_W : POS_W;
    localparam int CX_W   = (COL_W > POS_W) ? COL_W : POS_W;

    localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(3);
    localparam logic [DIM_W-1:0] WIDTH_MAX = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);

    typedef enum logic [1:0] {
        DIR_HORIZ,
        DIR_DIAG_POS,
        DIR_VERT,
        DIR_DIAG_NEG
    } t_dir;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic             w_cfg_write;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_DIM_RESET;
            r_frame_height <= FRAME_DIM_RESET;
        end else if (w_cfg_write) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the programmed frame size into the supported range
    logic [DIM_W-1:0] w_width_raw, w_height_raw;
    logic [DIM_W-1:0] w_width_eff, w_height_eff;

    assign w_width_raw  = DIM_W'(r_frame_width);
    assign w_height_raw = DIM_W'(r_frame_height);

    always_comb begin
        if (w_width_raw < DIM_MIN) begin
            w_width_eff = DIM_MIN;
        end else if (w_width_raw > WIDTH_MAX) begin
            w_width_eff = WIDTH_MAX;
        end else begin
            w_width_eff = w_width_raw;
        end
        if (w_height_raw < DIM_MIN) begin
            w_height_eff = DIM_MIN;
        end else if (w_height_raw > HEIGHT_MAX) begin
            w_height_eff = HEIGHT_MAX;
        end else begin
            w_height_eff = w_height_raw;
        end
    end

    // ------------------------------------------------------------------
    // Handshake: stage 1 holds the item whose line-buffer read is in
    // flight; it retires into the output register or is dropped if it
    // carries no result.
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic w_out_free;
    logic w_s1_adv;
    logic w_accept;

    assign w_out_free = !o_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_s1_adv   = r_s1_valid && w_out_free;

    // ------------------------------------------------------------------
    // Raster position counters
    // ------------------------------------------------------------------
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             w_last_col, w_last_row;

    assign w_last_col = (DIM_W'(r_col) + DIM_W'(1)) == w_width_eff;
    assign w_last_row = (DIM_W'(r_row) + DIM_W'(1)) == w_height_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_cfg_write) begin
            // restart the frame on any register write
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            if (w_last_col) begin
                r_col <= '0;
                r_row <= w_last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Line buffers: one memory holds both magnitude lines side by side
    // ({older, newer}), one holds the previous line's angles. Read on
    // accept, write back as the item retires from stage 1.
    // ------------------------------------------------------------------
    logic [2*MAG_W-1:0] r_mag_mem [MAX_WIDTH];
    logic [ANGLE_W-1:0] r_ang_mem [MAX_WIDTH];
    logic [2*MAG_W-1:0] r_mag_rd;
    logic [ANGLE_W-1:0] r_ang_rd;

    logic [MAG_W-1:0] w_top, w_mid;
    assign w_top = r_mag_rd[2*MAG_W-1:MAG_W];
    assign w_mid = r_mag_rd[MAG_W-1:0];

    // stage 1 payload
    logic [MAG_W-1:0]   r_s1_mag;
    logic [ANGLE_W-1:0] r_s1_ang;
    logic [COL_W-1:0]   r_s1_col;
    logic [ROW_W-1:0]   r_s1_row;
    logic               r_s1_emit;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mag_rd <= r_mag_mem[r_col];
            r_ang_rd <= r_ang_mem[r_col];
        end
        if (w_s1_adv) begin
            r_mag_mem[r_s1_col] <= {w_mid, r_s1_mag};
            r_ang_mem[r_s1_col] <= r_s1_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_mag  <= i_in_item.grad_magnitude;
            r_s1_ang  <= i_in_item.grad_angle;
            r_s1_col  <= r_col;
            r_s1_row  <= r_row;
            r_s1_emit <= (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
        end
    end

    // ------------------------------------------------------------------
    // 3x3 window (row 0 = oldest line, column 2 = newest pixel) and the
    // two-deep delay of the centre pixel's angle. Shift on retire.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0]   r_win [3][3];
    logic [ANGLE_W-1:0] r_cad [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
            r_cad[0] <= '0;
            r_cad[1] <= '0;
        end else if (w_s1_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= w_top;
            r_win[1][2] <= w_mid;
            r_win[2][2] <= r_s1_mag;
            r_cad[1]    <= r_cad[0];
            r_cad[0]    <= r_ang_rd;
        end
    end

    // ------------------------------------------------------------------
    // Suppression on the shifted window: centre is the old right-middle
    // column, angle is the one about to move into the second delay slot.
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0] w_ang_wrap, w_ang_fold;
    t_dir               w_dir;
    logic [MAG_W-1:0]   w_ctr, w_n1, w_n2, w_thin;

    always_comb begin
        // fold onto 0..359; the four bands repeat every half turn
        w_ang_wrap = (r_cad[0] >= ANG_FULL) ? r_cad[0] - ANG_FULL : r_cad[0];
        w_ang_fold = (w_ang_wrap >= ANG_HALF) ? w_ang_wrap - ANG_HALF : w_ang_wrap;
        if (w_ang_fold <= ANG_B22) begin
            w_dir = DIR_HORIZ;
        end else if (w_ang_fold <= ANG_B67) begin
            w_dir = DIR_DIAG_NEG;
        end else if (w_ang_fold <= ANG_B112) begin
            w_dir = DIR_VERT;
        end else if (w_ang_fold <= ANG_B157) begin
            w_dir = DIR_DIAG_POS;
        end else begin
            w_dir = DIR_HORIZ;
        end
    end

    always_comb begin
        w_ctr = r_win[1][2];
        case (w_dir)
            DIR_HORIZ: begin
                w_n1 = r_win[1][1];
                w_n2 = w_mid;
            end
            DIR_DIAG_POS: begin
                w_n1 = r_win[2][1];
                w_n2 = w_top;
            end
            DIR_VERT: begin
                w_n1 = r_win[0][2];
                w_n2 = r_win[2][2];
            end
            DIR_DIAG_NEG: begin
                w_n1 = r_win[0][1];
                w_n2 = r_s1_mag;
            end
            default: begin
                w_n1 = '0;
                w_n2 = '0;
            end
        endcase
        w_thin = ((w_ctr > w_n1) && (w_ctr > w_n2)) ? w_ctr : '0;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [RX_W-1:0] w_row_m1;
    logic [CX_W-1:0] w_col_m1;

    assign w_row_m1 = RX_W'(r_s1_row) - RX_W'(1);
    assign w_col_m1 = CX_W'(r_s1_col) - CX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_s1_adv && r_s1_emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_emit) begin
            o_out_item.out_row       <= w_row_m1[POS_W-1:0];
            o_out_item.out_col       <= w_col_m1[POS_W-1:0];
            o_out_item.thinned_value <= w_thin;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_stall_needs_s1, o_in_stall, r_s1_valid, "input stalled with stage 1 empty")
    `ASSERT_IMPL(a_no_same_entry, w_accept && w_s1_adv, r_col != r_s1_col, "line buffer clash")
    `ASSERT_CLK(a_col_in_frame, DIM_W'(r_col) < w_width_eff, "column beyond frame width")
    `ASSERT_CLK(a_row_in_frame, DIM_W'(r_row) < w_height_eff, "row beyond frame height")

endmodule

`default_nettype wire

// ===== tb/tb_canny_non_maxima_suppression.sv =====
// ----------------------------------------------------------------------------
// tb_canny_non_maxima_suppression
// Self-checking bench for the 3x3 non-maximum suppression stage. A tracker
// keeps its own line buffers, window and counters, predicts one thinned item
// per interior pixel and compares it with what leaves the output port.
// Stimulus runs the reset frame size, a few hand-built 3x3 frames and short
// random frame sizes with angles clustered on the band edges. Both ports
// idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_canny_non_maxima_suppression;

    import cnms_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int PIPE_LATENCY   = 2;
    localparam int SETTLE_CYCLES  = PIPE_LATENCY + 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PIXELS  = 200;
    localparam int MIN_DIM        = 3;

    // Indexes past the register list: a write there only restarts the frame
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    typedef enum logic [1:0] {
        DIR_HORIZONTAL,
        DIR_RISING,
        DIR_VERTICAL,
        DIR_FALLING
    } t_nms_dir;

    // ------------------------------------------------------------------------
    // Tracker: mirrors the line buffers and the window, queues thinned items
    // ------------------------------------------------------------------------
    class nms_tracker;
        logic [MAG_W-1:0]   mag_upper [DEF_MAX_WIDTH];
        logic [MAG_W-1:0]   mag_lower [DEF_MAX_WIDTH];
        logic [ANGLE_W-1:0] angle_row [DEF_MAX_WIDTH];
        logic [MAG_W-1:0]   win [3][3];
        logic [ANGLE_W-1:0] angle_dly [2];
        int unsigned        col;
        int unsigned        row;
        logic [CFG_W-1:0]   width_reg;
        logic [CFG_W-1:0]   height_reg;
        t_pixel_out         thinned_due [$];
        int                 failures;
        int                 pixels;
        int                 results;
        int                 kept;
        int                 writes;
        int                 dir_hits [4];

        function new();
            foreach (mag_upper[i]) begin
                mag_upper[i] = '0;
                mag_lower[i] = '0;
                angle_row[i] = '0;
            end
            foreach (win[r, c]) win[r][c] = '0;
            angle_dly[0] = '0;
            angle_dly[1] = '0;
            col        = 0;
            row        = 0;
            width_reg  = FRAME_DIM_RESET;
            height_reg = FRAME_DIM_RESET;
            failures   = 0;
            pixels     = 0;
            results    = 0;
            kept       = 0;
            writes     = 0;
            foreach (dir_hits[i]) dir_hits[i] = 0;
        endfunction

        function int unsigned span(logic [CFG_W-1:0] v, int unsigned maxv);
            if (v < MIN_DIM) return MIN_DIM;
            if (v > maxv) return maxv;
            return v;
        endfunction

        // Fold the angle to -359..360 half-degrees and pick its band
        function t_nms_dir quantise(logic [ANGLE_W-1:0] raw);
            int a;
            int b22;
            int b67;
            int b112;
            int b157;
            b22  = int'(ANG_B22);
            b67  = int'(ANG_B67);
            b112 = int'(ANG_B112);
            b157 = int'(ANG_B157);
            a = int'(raw);
            if (a >= int'(ANG_FULL)) a -= int'(ANG_FULL);
            if (a > int'(ANG_HALF)) a -= int'(ANG_FULL);
            if ((a > -b22 && a <= b22) || a > b157 || a <= -b157) return DIR_HORIZONTAL;
            if ((a > -b67 && a <= -b22) || (a > b112 && a <= b157)) return DIR_RISING;
            if ((a > -b112 && a <= -b67) || (a > b67 && a <= b112)) return DIR_VERTICAL;
            return DIR_FALLING;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_FRAME_WIDTH) width_reg = val;
            else if (idx == REG_FRAME_HEIGHT) height_reg = val;
            // every write, spare indexes too, restarts the frame
            col = 0;
            row = 0;
            writes++;
        endfunction

        function void take_pixel(t_pixel_in px);
            int unsigned      w;
            int unsigned      h;
            logic [MAG_W-1:0] upper;
            logic [MAG_W-1:0] lower;
            logic [MAG_W-1:0] n1;
            logic [MAG_W-1:0] n2;
            t_nms_dir         dir;
            t_pixel_out       res;
            w = span(width_reg, DEF_MAX_WIDTH);
            h = span(height_reg, DEF_MAX_HEIGHT);
            pixels++;

            // shift the column of line buffers up by one row
            upper = mag_upper[col];
            lower = mag_lower[col];
            mag_upper[col] = lower;
            mag_lower[col] = px.grad_magnitude;
            angle_dly[1]   = angle_dly[0];
            angle_dly[0]   = angle_row[col];
            angle_row[col] = px.grad_angle;

            for (int r = 0; r < 3; r++) begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = upper;
            win[1][2] = lower;
            win[2][2] = px.grad_magnitude;

            if (row >= 2 && col >= 2) begin
                dir = quantise(angle_dly[1]);
                case (dir)
                    DIR_HORIZONTAL: begin
                        n1 = win[1][0];
                        n2 = win[1][2];
                    end
                    DIR_RISING: begin
                        n1 = win[2][0];
                        n2 = win[0][2];
                    end
                    DIR_VERTICAL: begin
                        n1 = win[0][1];
                        n2 = win[2][1];
                    end
                    default: begin
                        n1 = win[0][0];
                        n2 = win[2][2];
                    end
                endcase
                res.out_row       = POS_W'(row - 1);
                res.out_col       = POS_W'(col - 1);
                res.thinned_value = (win[1][1] > n1 && win[1][1] > n2) ? win[1][1] : '0;
                thinned_due.push_back(res);
                dir_hits[dir]++;
                results++;
                if (res.thinned_value != 0) kept++;
            end

            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_thinned(t_pixel_out got);
            t_pixel_out want;
            if (thinned_due.size() == 0) begin
                $display("%0t: unexpected item row %0d col %0d value %0d, expected none",
                         $time, got.out_row, got.out_col, got.thinned_value);
                failures++;
                return;
            end
            want = thinned_due.pop_front();
            compare_field("out_row", 16'(want.out_row), 16'(got.out_row));
            compare_field("out_col", 16'(want.out_col), 16'(got.out_col));
            compare_field("thinned_value", 16'(want.thinned_value), 16'(got.thinned_value));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block
    // ------------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_pixel_in            i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_pixel_out           o_out_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    nms_tracker tracker;
    bit         no_idle      = 1'b0;
    int         stall_left   = 0;
    int         quiet_cycles = 0;

    canny_non_maxima_suppression u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Result side: check each accepted item, then hold stall for a random
    // number of cycles before taking the next one
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (o_out_valid && !i_out_stall) begin
            tracker.check_thinned(o_out_item);
            stall_left = no_idle ? 0 : $urandom_range(0, 3);
            i_out_stall <= (stall_left != 0);
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= (stall_left != 0);
        end
    end

    // Watchdog: end the run if no channel moves an item for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Pixel generation
    // ------------------------------------------------------------------------

    // Half of the angles sit on or next to a band edge, some of them lifted
    // into the 720..1023 range that the block folds back
    function automatic logic [ANGLE_W-1:0] random_angle();
        int band_edges [11] = '{0, int'(ANG_B22), int'(ANG_B67), int'(ANG_B112),
                                int'(ANG_B157), int'(ANG_HALF), int'(ANG_FULL - ANG_B157),
                                int'(ANG_FULL - ANG_B112), int'(ANG_FULL - ANG_B67),
                                int'(ANG_FULL - ANG_B22), int'(ANG_FULL)};
        int a;
        if ($urandom_range(0, 1) == 0) return ANGLE_W'($urandom);
        a = band_edges[$urandom_range(0, 10)] + int'($urandom_range(0, 2)) - 1;
        if (a >= 0 && a < (1 << ANGLE_W) - int'(ANG_FULL) && $urandom_range(0, 1) == 1)
            a += int'(ANG_FULL);
        return ANGLE_W'(a);
    endfunction

    // Small values and the rails make ties between neighbours common
    function automatic logic [MAG_W-1:0] random_magnitude();
        case ($urandom_range(0, 3))
            0: return MAG_W'($urandom);
            1: return ($urandom_range(0, 1) != 0) ? {MAG_W{1'b1}} : {MAG_W{1'b0}};
            2: return MAG_W'($urandom_range(0, 3));
            default: return MAG_W'($urandom_range(250, 255));
        endcase
    endfunction

    function automatic t_pixel_in random_pixel();
        t_pixel_in px;
        px.grad_magnitude = random_magnitude();
        px.grad_angle     = random_angle();
        return px;
    endfunction

    // Mostly small frames; now and then a value below the floor or above
    // the widest line, which the block clamps
    function automatic logic [CFG_W-1:0] random_dim(bit for_height);
        case ($urandom_range(0, 11))
            0: return CFG_W'($urandom_range(0, MIN_DIM - 1));
            1: return CFG_W'($urandom_range(DEF_MAX_WIDTH + 1, (1 << CFG_W) - 1));
            2: return for_height ? CFG_W'(DEF_MAX_HEIGHT) : CFG_W'(MIN_DIM);
            default: return for_height ? CFG_W'($urandom_range(MIN_DIM, 8))
                                       : CFG_W'($urandom_range(MIN_DIM, 24));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Wait a random gap, present the item and hold it until it is taken
    task automatic send_pixel(input t_pixel_in px);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_item  <= px;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_pixel(px);
    endtask

    // Drop valid and wait until every expected item has left the block
    task automatic wait_idle(input int settle);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.thinned_due.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // Leaves valid high so that writes can follow back to back
    task automatic put_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_register(idx, val);
    endtask

    task automatic end_writes();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input bit stray);
        wait_idle(SETTLE_CYCLES);
        if ($urandom_range(0, 1) == 0) begin
            put_register(REG_FRAME_WIDTH, w);
            put_register(REG_FRAME_HEIGHT, h);
        end else begin
            put_register(REG_FRAME_HEIGHT, h);
            put_register(REG_FRAME_WIDTH, w);
        end
        if (stray)
            put_register(($urandom_range(0, 1) != 0) ? REG_SPARE_2 : REG_SPARE_3,
                         CFG_W'($urandom));
        end_writes();
    endtask

    // Send one 3x3 frame in raster order; only the centre angle matters
    task automatic send_tile(input logic [8:0][MAG_W-1:0] mags,
                             input logic [ANGLE_W-1:0] centre_angle);
        t_pixel_in px;
        for (int k = 8; k >= 0; k--) begin
            px.grad_magnitude = mags[k];
            px.grad_angle     = (k == 4) ? centre_angle : random_angle();
            send_pixel(px);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int random_pixels;
        int phase_len;
        random_pixels = 0;
        tracker = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset frame size: two full lines and a few interior pixels
        repeat (2 * FRAME_DIM_RESET + 40) send_pixel(random_pixel());

        // Hand-built tiles. A strict peak on a folded angle is kept, a flat
        // tile gives zero, then the frame wraps into the next tile.
        set_frame(CFG_W'(MIN_DIM), CFG_W'(MIN_DIM), 1'b0);
        send_tile({8'd254, 8'd254, 8'd254, 8'd254, 8'd255, 8'd254, 8'd254, 8'd254, 8'd254},
                  {ANGLE_W{1'b1}});
        send_tile({9{8'd0}}, ANG_FULL);

        // Sizes below the floor clamp; writes past the register list restart
        wait_idle(SETTLE_CYCLES);
        put_register(REG_FRAME_WIDTH, '0);
        put_register(REG_FRAME_HEIGHT, CFG_W'(MIN_DIM - 1));
        put_register(REG_SPARE_2, '1);
        put_register(REG_SPARE_3, '0);
        end_writes();
        send_tile({8'd10, 8'd200, 8'd10, 8'd50, 8'd100, 8'd50, 8'd10, 8'd0, 8'd10},
                  ANG_FULL - ANG_B22);

        // Random frames; every so often drain the block completely
        while (random_pixels < RANDOM_PIXELS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            set_frame(random_dim(1'b0), random_dim(1'b1), $urandom_range(0, 3) == 0);
            phase_len = $urandom_range(10, 60);
            repeat (phase_len) begin
                if (random_pixels % 257 == 128) wait_idle(0);
                send_pixel(random_pixel());
                random_pixels++;
            end
        end
        no_idle = 1'b0;

        wait_idle(SETTLE_CYCLES);
        $display("Ran %0d pixels and %0d register writes; %0d interior items, %0d kept.",
                 tracker.pixels, tracker.writes, tracker.results, tracker.kept);
        $display("Bands hit: horizontal %0d, +45 %0d, vertical %0d, -45 %0d.",
                 tracker.dir_hits[DIR_HORIZONTAL], tracker.dir_hits[DIR_RISING],
                 tracker.dir_hits[DIR_VERTICAL], tracker.dir_hits[DIR_FALLING]);
        if (tracker.failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
